// File: sv/eptc_pkg.sv
// ----------------------------------------------------------------------------
// eptc_pkg: shared constants for the epoch seconds to calendar unit
// Reciprocal multipliers for the constant divisions, calendar constants and
// the leap year helpers used by the date path.
// ----------------------------------------------------------------------------
package eptc_pkg;

  localparam int unsigned PIPE_DEPTH = 8;

  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [8:0]  DAYS_PER_LEAP_YEAR = 9'd366;
  localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
  localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;
  localparam logic [11:0] CENTURY_2000       = 12'd2000;
  localparam logic [11:0] CENTURY_2100       = 12'd2100;
  localparam logic [4:0]  LAST_DAY_DEC       = 5'd31;
  localparam logic [3:0]  MONTH_DEC          = 4'd11;
  localparam logic [3:0]  MONTH_MAR          = 4'd2;

  // t / 86400 = (t >> 7) / 675; reciprocal exact for 25-bit dividends
  localparam int unsigned DAY_SHIFT  = 35;
  localparam logic [25:0] DAY_MUL    = 26'((64'd1 << DAY_SHIFT) / 64'd675 + 64'd1);
  // days / 365 for 16-bit dividends
  localparam int unsigned YEAR_SHIFT = 25;
  localparam logic [16:0] YEAR_MUL   = 17'((64'd1 << YEAR_SHIFT) / 64'd365 + 64'd1);
  // sod / 3600 = (sod >> 4) / 225 for 13-bit dividends
  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_MUL   = 14'((64'd1 << HOUR_SHIFT) / 64'd225 + 64'd1);
  // rem / 60 for 12-bit dividends
  localparam int unsigned MIN_SHIFT  = 18;
  localparam logic [12:0] MIN_MUL    = 13'((64'd1 << MIN_SHIFT) / 64'd60 + 64'd1);

  function automatic logic leap_year(input logic [11:0] year);
    return (year[1:0] == 2'b00) && (year != CENTURY_2100);
  endfunction

  // leap days in the years 1970 .. year-1
  function automatic logic [5:0] leap_days_before(input logic [11:0] year);
    logic [11:0] c100;
    logic [11:0] c400;
    logic [11:0] n;
    c100 = (year >= CENTURY_2100) ? 12'd21 : ((year >= CENTURY_2000) ? 12'd20 : 12'd19);
    c400 = (year >= CENTURY_2000) ? 12'd5 : 12'd4;
    n = {2'b00, year[11:2]} - c100 + c400 - LEAPS_BEFORE_EPOCH - 12'(leap_year(year));
    return n[5:0];
  endfunction

  // first day of each month counted from 0, one day later from March on in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      default: base = 9'd334;
    endcase
    return base + 9'(leap && (idx >= MONTH_MAR));
  endfunction

endpackage

// File: sv/eptc_day_split.sv
// ----------------------------------------------------------------------------
// eptc_day_split: whole days and second of day
// Two register stages: reciprocal divide by 86400, then the remainder.
// ----------------------------------------------------------------------------
module eptc_day_split (
  input  logic        clk,
  input  logic        advance,
  input  logic [31:0] epoch_seconds,
  output logic [15:0] days,
  output logic [16:0] sod
);
  import eptc_pkg::*;

  logic [31:0] t1;
  logic [15:0] days1;
  logic [50:0] dprod;
  logic [32:0] dsecs;

  assign dprod = 51'(epoch_seconds[31:7]) * 51'(DAY_MUL);
  assign dsecs = 33'(days1) * 33'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (advance) begin
      t1    <= epoch_seconds;
      days1 <= dprod[DAY_SHIFT +: 16];
      days  <= days1;
      sod   <= 17'(t1 - dsecs[31:0]);
    end
  end

endmodule

// File: sv/eptc_clock_unit.sv
// ----------------------------------------------------------------------------
// eptc_clock_unit: hour, minute and second from the second of day
// Six register stages; the first four hold one multiply each, the last two delay.
// ----------------------------------------------------------------------------
module eptc_clock_unit (
  input  logic        clk,
  input  logic        advance,
  input  logic [16:0] sod,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);
  import eptc_pkg::*;

  logic [16:0] sod3;
  logic [4:0]  hour3, hour4, hour5, hour6, hour7;
  logic [11:0] rem4, rem5;
  logic [5:0]  min5, min6, min7;
  logic [5:0]  sec6, sec7;
  logic [26:0] hprod;
  logic [16:0] hsecs;
  logic [24:0] mprod;
  logic [11:0] msecs;

  assign hprod = 27'(sod[16:4]) * 27'(HOUR_MUL);
  assign hsecs = 17'(hour3) * 17'(SECS_PER_HOUR);
  assign mprod = 25'(rem4) * 25'(MIN_MUL);
  assign msecs = 12'(min5) * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (advance) begin
      sod3  <= sod;
      hour3 <= hprod[HOUR_SHIFT +: 5];
      hour4 <= hour3;
      rem4  <= 12'(sod3 - hsecs);
      hour5 <= hour4;
      rem5  <= rem4;
      min5  <= mprod[MIN_SHIFT +: 6];
      hour6 <= hour5;
      min6  <= min5;
      sec6  <= 6'(rem5 - msecs);
      hour7 <= hour6;
      min7  <= min6;
      sec7  <= sec6;
      hour_of_day      <= hour7;
      minute_of_hour   <= min7;
      second_of_minute <= sec7;
    end
  end

endmodule

// File: sv/eptc_date_unit.sv
// ----------------------------------------------------------------------------
// eptc_date_unit: year, month and day from the day count
// Six register stages: year estimate, day within estimate, year correction,
// day of year, month search, day of month.
// ----------------------------------------------------------------------------
module eptc_date_unit (
  input  logic        clk,
  input  logic        advance,
  input  logic [15:0] days,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [11:0] year_number
);
  import eptc_pkg::*;

  logic [15:0] days3;
  logic [7:0]  n3, n4;
  logic [8:0]  rem4;
  logic [5:0]  lb4;
  logic [11:0] year5, year6, year7;
  logic [9:0]  rem5;
  logic [8:0]  doy6, doy7;
  logic        leap6, leap7;
  logic [3:0]  midx7;
  logic        over7;

  logic [32:0] yprod;
  logic [16:0] ydays;
  logic        corr;
  logic [5:0]  lb5;
  logic [3:0]  midx;
  logic [8:0]  mstart;

  assign yprod  = 33'(days) * 33'(YEAR_MUL);
  assign ydays  = 17'(n3) * 17'(DAYS_PER_YEAR);
  assign corr   = rem4 < 9'(lb4);
  assign lb5    = leap_days_before(year5);
  assign mstart = month_start(midx7, leap7);

  always_comb begin
    midx = '0;
    for (int k = 1; k < 12; k++) begin
      midx = midx + 4'(doy6 >= month_start(4'(k), leap6));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      days3 <= days;
      n3    <= yprod[YEAR_SHIFT +: 8];
      n4    <= n3;
      rem4  <= 9'(days3 - ydays[15:0]);
      lb4   <= leap_days_before(EPOCH_YEAR + 12'(n3));
      year5 <= EPOCH_YEAR + 12'(n4) - 12'(corr);
      rem5  <= 10'(rem4) + (corr ? 10'(DAYS_PER_YEAR) : 10'd0);
      year6 <= year5;
      leap6 <= leap_year(year5);
      doy6  <= (rem5 >= 10'(lb5)) ? 9'(rem5 - 10'(lb5)) : 9'd0;
      year7 <= year6;
      leap7 <= leap6;
      doy7  <= doy6;
      midx7 <= midx;
      over7 <= doy6 >= (leap6 ? DAYS_PER_LEAP_YEAR : DAYS_PER_YEAR);
      year_number  <= year7;
      month_number <= over7 ? (MONTH_DEC + 4'd1) : (midx7 + 4'd1);
      day_of_month <= over7 ? LAST_DAY_DEC : 5'(doy7 - mstart + 9'd1);
    end
  end

endmodule

// File: sv/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 to Gregorian date
// Usage: present a 32-bit unsigned second count on epoch_seconds with
// epoch_valid; it is taken on a transfer (epoch_valid and epoch_ready high).
// The date comes out on date_valid/date_ready with day, month, year, hour,
// minute and second each on a port of its own.
// Throughput: one conversion per cycle while the output is not stalled; the
// 8-stage register pipeline spreads the multiplies and compares over its
// stages, and all stages move together on a common advance.
// Stall: while the last stage holds a date that date_ready does not take,
// the whole pipeline holds and epoch_ready is low; nothing is dropped.
// Reset: rst (synchronous) clears the stage valid bits; the pipeline is
// then empty and ready at once.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        epoch_valid,
  output logic        epoch_ready,
  input  logic [31:0] epoch_seconds,
  output logic        date_valid,
  input  logic        date_ready,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [11:0] year_number,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);
  import eptc_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  advance;
  logic [15:0]           days;
  logic [16:0]           sod;

  assign advance     = !vld[PIPE_DEPTH-1] || date_ready;
  assign epoch_ready = advance;
  assign date_valid  = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_DEPTH-2:0], epoch_valid};
    end
  end

  eptc_day_split u_split (
    .clk           (clk),
    .advance       (advance),
    .epoch_seconds (epoch_seconds),
    .days          (days),
    .sod           (sod)
  );

  eptc_clock_unit u_clock (
    .clk              (clk),
    .advance          (advance),
    .sod              (sod),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  eptc_date_unit u_date (
    .clk          (clk),
    .advance      (advance),
    .days         (days),
    .day_of_month (day_of_month),
    .month_number (month_number),
    .year_number  (year_number)
  );

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> vld == $past(vld))
    else $error("pipeline moved while stalled");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> month_number >= 4'd1 && month_number <= 4'd12 &&
                   day_of_month >= 5'd1)
    else $error("month or day out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> year_number >= 12'd1970 && year_number <= 12'd2106)
    else $error("year out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> hour_of_day < 5'd24 && minute_of_hour < 6'd60 &&
                   second_of_minute < 6'd60)
    else $error("time of day out of range");
`endif

endmodule
